// ===== rtl/bplms_pkg.sv =====
`default_nettype none

package bplms_pkg;

    // configuration register map, word index = paddr / 4
    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_VLONG      = 2'd2,
        REG_MARQUEE    = 2'd3
    } cfg_reg_t;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned PAT_W  = 4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] VLONG_RST      = 16'd4000;
    localparam logic [CFG_W-1:0] MARQUEE_RST    = 16'd250;

    // level codes of the active-low button
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/button_press_length_mode_stepper_top.sv =====
`default_nettype none

// a result word is valid once its tick word, loaded into the input register at
// acceptance, has moved on into the result register, which waits while stalled
// throughput: one tick word per cycle unless out_ready stalls; the debounce,
// hold and marquee compares all sit in one stage between input and result registers
// reset: rst_n clears all timers, the pattern index and the handshake state
// and reloads the configuration registers with their defaults
module button_press_length_mode_stepper_top #(
    parameter int unsigned NUM_PATTERNS = 9
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bplms_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bplms_pkg::DATA_W-1:0]    pwdata,
    output logic      [bplms_pkg::DATA_W-1:0]    prdata,
    output logic                                 pready,
    // tick words
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            raw_level,
    // result words
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [bplms_pkg::PAT_W-1:0]     pattern_index,
    output logic                                 button_level,
    output logic                                 marquee_update,
    output logic                                 marquee_side
);

    localparam int unsigned TW = bplms_pkg::TIME_W;
    localparam int unsigned PW = bplms_pkg::PAT_W;
    localparam int unsigned CW = bplms_pkg::CFG_W;

    // last index of the press cycle and the test index
    localparam logic [PW-1:0] LAST_CYCLE = PW'(NUM_PATTERNS - 2);
    localparam logic [PW-1:0] TEST_IDX   = PW'(NUM_PATTERNS - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] debounce_reg;
    logic [CW-1:0] long_press_reg;
    logic [CW-1:0] vlong_press_reg;
    logic [CW-1:0] marquee_period_reg;

    bplms_pkg::cfg_reg_t cfg_sel;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = bplms_pkg::cfg_reg_t'(paddr[bplms_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg       <= bplms_pkg::DEBOUNCE_RST;
            long_press_reg     <= bplms_pkg::LONG_PRESS_RST;
            vlong_press_reg    <= bplms_pkg::VLONG_RST;
            marquee_period_reg <= bplms_pkg::MARQUEE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                bplms_pkg::REG_DEBOUNCE:   debounce_reg       <= pwdata[CW-1:0];
                bplms_pkg::REG_LONG_PRESS: long_press_reg     <= pwdata[CW-1:0];
                bplms_pkg::REG_VLONG:      vlong_press_reg    <= pwdata[CW-1:0];
                bplms_pkg::REG_MARQUEE:    marquee_period_reg <= pwdata[CW-1:0];
                default:                   debounce_reg       <= debounce_reg;
            endcase
        end
    end

    // read mux, registers are zero-extended to the bus width
    always_comb
    begin
        unique case (cfg_sel)
            bplms_pkg::REG_DEBOUNCE:   prdata = {{(bplms_pkg::DATA_W-CW){1'b0}}, debounce_reg};
            bplms_pkg::REG_LONG_PRESS: prdata = {{(bplms_pkg::DATA_W-CW){1'b0}}, long_press_reg};
            bplms_pkg::REG_VLONG:      prdata = {{(bplms_pkg::DATA_W-CW){1'b0}}, vlong_press_reg};
            bplms_pkg::REG_MARQUEE:    prdata = {{(bplms_pkg::DATA_W-CW){1'b0}}, marquee_period_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: input register feeding the result register
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic raw_reg;
    logic step;      // input word moves into the result register this cycle

    assign step     = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg <= raw_level;
        end
    end

    // ------------------------------------------------------------------
    // tick state
    // ------------------------------------------------------------------
    logic [TW-1:0] tick_now_reg;
    logic          raw_seen_reg;
    logic          level_reg;
    logic [TW-1:0] raw_change_time_reg;
    logic          press_held_reg;
    logic          long_done_reg;
    logic          vlong_done_reg;
    logic [TW-1:0] press_start_reg;
    logic [PW-1:0] pattern_reg;
    logic [TW-1:0] toggle_time_reg;
    logic          next_side_a_reg;
    logic          side_shown_reg;

    logic [TW-1:0] raw_change_time_next;
    logic          level_next;
    logic          press_held_next;
    logic          long_done_next;
    logic          vlong_done_next;
    logic [TW-1:0] press_start_next;
    logic [PW-1:0] pattern_next;
    logic [TW-1:0] toggle_time_next;
    logic          next_side_a_next;
    logic          side_shown_next;
    logic          update_next;

    // all three elapsed times come straight from stored timestamps so the
    // subtracts run in parallel; a timestamp taken this tick means zero elapsed
    logic [TW-1:0] deb_elapsed;
    logic [TW-1:0] hold_elapsed;
    logic [TW-1:0] toggle_elapsed;
    logic          raw_changed;
    logic          deb_ok;
    logic          accept;
    logic          press;
    logic          release_evt;
    logic          long_ok;
    logic          vlong_ok;
    logic          long_fire;
    logic          vlong_fire;
    logic [PW-1:0] pat_short;
    logic          is_marquee;

    assign deb_elapsed    = tick_now_reg - raw_change_time_reg;
    assign hold_elapsed   = tick_now_reg - press_start_reg;
    assign toggle_elapsed = tick_now_reg - toggle_time_reg;

    always_comb
    begin
        // debounce
        raw_changed          = (raw_reg != raw_seen_reg);
        raw_change_time_next = raw_changed ? tick_now_reg : raw_change_time_reg;
        deb_ok      = raw_changed ? (debounce_reg == '0)
                                  : (deb_elapsed >= TW'(debounce_reg));
        accept      = (raw_reg != level_reg) && deb_ok;
        level_next  = accept ? raw_reg : level_reg;
        press       = accept && (raw_reg == bplms_pkg::LEVEL_PRESSED);
        release_evt = accept && (raw_reg == bplms_pkg::LEVEL_RELEASED);

        // short press
        press_held_next  = press ? 1'b1 : (release_evt ? 1'b0 : press_held_reg);
        press_start_next = press ? tick_now_reg : press_start_reg;
        pat_short        = (press && (pattern_reg < LAST_CYCLE))
                           ? pattern_reg + PW'(1) : pattern_reg;

        // long and very long hold
        long_ok    = press ? (long_press_reg == '0)
                           : (hold_elapsed >= TW'(long_press_reg));
        vlong_ok   = press ? (vlong_press_reg == '0)
                           : (hold_elapsed >= TW'(vlong_press_reg));
        long_fire  = press_held_next && !(long_done_reg && !press) && long_ok;
        vlong_fire = press_held_next && !(vlong_done_reg && !press) && vlong_ok;
        long_done_next  = long_fire  || (long_done_reg  && !press);
        vlong_done_next = vlong_fire || (vlong_done_reg && !press);

        pattern_next = pat_short;
        if (long_fire)
        begin
            pattern_next = '0;
        end
        if (vlong_fire)
        begin
            pattern_next = TEST_IDX;
        end

        // marquee on the new index
        is_marquee  = pattern_next[0] && (pattern_next <= LAST_CYCLE);
        update_next = is_marquee && (toggle_elapsed >= TW'(marquee_period_reg));
        toggle_time_next = update_next ? tick_now_reg : toggle_time_reg;
        side_shown_next  = update_next ? next_side_a_reg : side_shown_reg;
        next_side_a_next = update_next ? !next_side_a_reg : next_side_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg        <= '0;
            raw_seen_reg        <= bplms_pkg::LEVEL_RELEASED;
            level_reg           <= bplms_pkg::LEVEL_RELEASED;
            raw_change_time_reg <= '0;
            press_held_reg      <= 1'b0;
            long_done_reg       <= 1'b0;
            vlong_done_reg      <= 1'b0;
            press_start_reg     <= '0;
            pattern_reg         <= '0;
            toggle_time_reg     <= '0;
            next_side_a_reg     <= 1'b1;
            side_shown_reg      <= 1'b0;
        end
        else if (step)
        begin
            tick_now_reg        <= tick_now_reg + TW'(1);
            raw_seen_reg        <= raw_reg;
            level_reg           <= level_next;
            raw_change_time_reg <= raw_change_time_next;
            press_held_reg      <= press_held_next;
            long_done_reg       <= long_done_next;
            vlong_done_reg      <= vlong_done_next;
            press_start_reg     <= press_start_next;
            pattern_reg         <= pattern_next;
            toggle_time_reg     <= toggle_time_next;
            next_side_a_reg     <= next_side_a_next;
            side_shown_reg      <= side_shown_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (step)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pattern_index  <= pattern_next;
            button_level   <= level_next;
            marquee_update <= update_next;
            marquee_side   <= side_shown_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a marquee side is only driven from an odd cycle index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && marquee_update) |-> (pattern_index[0] && (pattern_index <= LAST_CYCLE)))
        else $error("marquee update outside a marquee index");

    // the index never leaves the pattern range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pattern_index <= TEST_IDX))
        else $error("pattern index out of range");

    // the next side is always the opposite of the side last shown
    assert property (@(posedge clk) disable iff (!rst_n)
        next_side_a_reg != side_shown_reg)
        else $error("marquee side tracking out of step");

    // a word in the input register moves on into the result register in the
    // following cycle when the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid) |=> out_valid)
        else $error("input word did not advance");

endmodule

`default_nettype wire

// ===== verif/tb_button_press_length_mode_stepper_top.sv =====
`timescale 1ns / 100ps

module tb_button_press_length_mode_stepper_top;

    localparam int unsigned PW  = bplms_pkg::PAT_W;
    localparam int unsigned AW  = bplms_pkg::ADDR_W;
    localparam int unsigned DW  = bplms_pkg::DATA_W;
    localparam int unsigned CW  = bplms_pkg::CFG_W;
    localparam int unsigned TMW = bplms_pkg::TIME_W;

    localparam int NUM_PAT = 9;
    // last index reached by short presses, and the test index
    localparam logic [PW-1:0] LAST_CYCLE = PW'(NUM_PAT - 2);
    localparam logic [PW-1:0] TEST_IDX   = PW'(NUM_PAT - 1);
    // generous cap on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 200000;

    // one result word as the block reports it
    typedef struct packed {
        logic [PW-1:0] pattern_index;
        logic          button_level;
        logic          marquee_update;
        logic          marquee_side;
    } result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port, idle from time zero
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [AW-1:0] paddr   = '0;
    logic [DW-1:0] pwdata  = '0;
    logic [DW-1:0] prdata;
    logic          pready;

    // tick words in, result words out
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic          raw_level = 1'b1;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [PW-1:0] pattern_index;
    logic          button_level;
    logic          marquee_update;
    logic          marquee_side;

    // raw levels waiting to be sent, and results predicted for accepted ticks
    logic    raw_tick_q[$];
    result_t step_result_q[$];

    // traffic shaping, set by the stimulus thread
    bit send_gaps_on = 1'b1;
    bit recv_stalls_on = 1'b1;

    int ticks_queued   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    result_t got_word;
    result_t want_word;

    // predictor copy of the configuration registers
    logic [CW-1:0] cfg_debounce;
    logic [CW-1:0] cfg_long;
    logic [CW-1:0] cfg_vlong;
    logic [CW-1:0] cfg_marquee;

    // predictor copy of the block state
    logic [TMW-1:0] tick_count;
    logic [TMW-1:0] change_stamp;
    logic [TMW-1:0] press_stamp;
    logic [TMW-1:0] toggle_stamp;
    logic           raw_last;
    logic           level_db;
    logic           holding;
    logic           long_fired;
    logic           vlong_fired;
    logic           side_a_next;
    logic           side_last;
    logic [PW-1:0]  pat;

    button_press_length_mode_stepper_top #(
        .NUM_PATTERNS(NUM_PAT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_level     (raw_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pattern_index (pattern_index),
        .button_level  (button_level),
        .marquee_update(marquee_update),
        .marquee_side  (marquee_side)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor back to its power-up state, registers at their defaults
    task automatic clear_model();
        cfg_debounce = bplms_pkg::DEBOUNCE_RST;
        cfg_long     = bplms_pkg::LONG_PRESS_RST;
        cfg_vlong    = bplms_pkg::VLONG_RST;
        cfg_marquee  = bplms_pkg::MARQUEE_RST;
        tick_count   = '0;
        change_stamp = '0;
        press_stamp  = '0;
        toggle_stamp = '0;
        raw_last     = bplms_pkg::LEVEL_RELEASED;
        level_db     = bplms_pkg::LEVEL_RELEASED;
        holding      = 1'b0;
        long_fired   = 1'b0;
        vlong_fired  = 1'b0;
        side_a_next  = 1'b1;
        side_last    = 1'b0;
        pat          = '0;
    endtask

    // one millisecond tick: debounce, press actions, then the marquee step
    function automatic result_t step_button(input logic raw);
        logic [TMW-1:0] now;
        result_t        r;
        now = tick_count;
        r.marquee_update = 1'b0;
        // any raw change restarts the debounce timer
        if (raw != raw_last)
        begin
            raw_last     = raw;
            change_stamp = now;
        end
        if (raw_last != level_db && (now - change_stamp) >= cfg_debounce)
        begin
            level_db = raw_last;
            if (level_db == bplms_pkg::LEVEL_PRESSED)
            begin
                holding     = 1'b1;
                long_fired  = 1'b0;
                vlong_fired = 1'b0;
                press_stamp = now;
                // short press steps the index, saturating; test index stays put
                if (pat < LAST_CYCLE)
                    pat = pat + 1'b1;
            end
            else
            begin
                holding = 1'b0;
            end
        end
        // hold actions fire once per press, long before very long
        if (holding && !long_fired && (now - press_stamp) >= cfg_long)
        begin
            long_fired = 1'b1;
            pat        = '0;
        end
        if (holding && !vlong_fired && (now - press_stamp) >= cfg_vlong)
        begin
            vlong_fired = 1'b1;
            pat         = TEST_IDX;
        end
        // marquee timer runs all the time, sides change only on odd cycle entries
        if (pat[0] && pat <= LAST_CYCLE && (now - toggle_stamp) >= cfg_marquee)
        begin
            toggle_stamp     = now;
            side_last        = side_a_next;
            side_a_next      = ~side_a_next;
            r.marquee_update = 1'b1;
        end
        tick_count      = now + 1'b1;
        r.pattern_index = pat;
        r.button_level  = level_db;
        r.marquee_side  = side_last;
        return r;
    endfunction

    // driver: predicts each accepted tick word, then offers the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            raw_level <= bplms_pkg::LEVEL_RELEASED;
            clear_model();
        end
        else
        begin
            if (in_valid && in_ready)
                step_result_q.push_back(step_button(raw_level));
            // a word still waiting keeps valid and level as they are
            if (!in_valid || in_ready)
            begin
                if (raw_tick_q.size() != 0 && !(send_gaps_on && $urandom_range(99) < 36))
                begin
                    in_valid  <= 1'b1;
                    raw_level <= raw_tick_q.pop_front();
                end
                else
                begin
                    // level is don't-care while idle, so shake it
                    in_valid  <= 1'b0;
                    raw_level <= 1'($urandom_range(1));
                end
            end
        end
    end

    // monitor: every accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_word = '{pattern_index, button_level, marquee_update, marquee_side};
                if (step_result_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: idx %0d lvl %0b upd %0b side %0b",
                                 got_word.pattern_index, got_word.button_level,
                                 got_word.marquee_update, got_word.marquee_side);
                end
                else
                begin
                    want_word = step_result_q.pop_front();
                    if (got_word !== want_word)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected idx %0d lvl %0b upd %0b side %0b,",
                                      " got idx %0d lvl %0b upd %0b side %0b"},
                                     want_word.pattern_index, want_word.button_level,
                                     want_word.marquee_update, want_word.marquee_side,
                                     got_word.pattern_index, got_word.button_level,
                                     got_word.marquee_update, got_word.marquee_side);
                    end
                end
            end
            out_ready <= !(recv_stalls_on && $urandom_range(99) < 36);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // queue count ticks of one raw level
    function automatic void add_ticks(input logic lvl, input int count);
        repeat (count)
        begin
            raw_tick_q.push_back(lvl);
            ticks_queued++;
        end
    endfunction

    // queue a fixed level pattern, oldest tick in the top bit
    function automatic void add_pattern(input logic [15:0] bits, input int count);
        for (int i = count - 1; i >= 0; i--)
            add_ticks(bits[i], 1);
    endfunction

    // wait until every word is sent and every result is back, then let the pipe drain
    task automatic wait_idle();
        while (raw_tick_q.size() != 0 || in_valid || step_result_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // setup then access cycle, junk in the upper data bits that the block drops
    task automatic write_reg(input bplms_pkg::cfg_reg_t idx, input logic [CW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bplms_pkg::REG_DEBOUNCE:   cfg_debounce = value;
            bplms_pkg::REG_LONG_PRESS: cfg_long     = value;
            bplms_pkg::REG_VLONG:      cfg_vlong    = value;
            bplms_pkg::REG_MARQUEE:    cfg_marquee  = value;
        endcase
    endtask

    // registers change only once the block has gone quiet
    task automatic set_config(input logic [CW-1:0] dbn, input logic [CW-1:0] lng,
                              input logic [CW-1:0] vlng, input logic [CW-1:0] marq);
        wait_idle();
        write_reg(bplms_pkg::REG_DEBOUNCE, dbn);
        write_reg(bplms_pkg::REG_LONG_PRESS, lng);
        write_reg(bplms_pkg::REG_VLONG, vlng);
        write_reg(bplms_pkg::REG_MARQUEE, marq);
    endtask

    // mostly bouncy presses held short, long or very long; some pure noise
    task automatic gen_presses(input int count);
        int target;
        int hold;
        int rel;
        target = ticks_queued + count;
        while (ticks_queued < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                repeat ($urandom_range(3)) add_pattern(16'b01, 2);
                case ($urandom_range(2))
                    0:       hold = cfg_debounce + $urandom_range(3);
                    1:       hold = cfg_debounce + cfg_long + $urandom_range(4);
                    default: hold = cfg_debounce + cfg_vlong + $urandom_range(6);
                endcase
                if (hold > 120)
                    hold = $urandom_range(120);
                add_ticks(bplms_pkg::LEVEL_PRESSED, hold);
                repeat ($urandom_range(3)) add_pattern(16'b10, 2);
                rel = cfg_debounce + $urandom_range(4);
                if (rel > 20)
                    rel = $urandom_range(12);
                add_ticks(bplms_pkg::LEVEL_RELEASED, rel);
            end
            else
            begin
                repeat ($urandom_range(1, 8)) add_ticks(1'($urandom_range(1)), 1);
            end
        end
    endtask

    // stimulus
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // glitches under the reset debounce time leave the reset state alone
        add_pattern(16'b1010, 4);

        // zero debounce and zero very long hold: press jumps to test mode,
        // a second press in test mode keeps the test index
        set_config(16'd0, 16'hFFFF, 16'd0, 16'd0);
        add_pattern(16'b010110, 6);

        // zero long hold fires right after the press step
        set_config(16'd2, 16'd0, 16'hFFFF, 16'd0);
        add_pattern(16'b000111, 6);

        // zero marquee period: a side on every tick of an odd index
        set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
        add_pattern(16'b001100111, 9);

        // random phases with fresh registers each time
        for (int p = 0; p < 6; p++)
        begin
            if (p == 3)
                set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                set_config(16'($urandom_range(4)), 16'($urandom_range(2, 40)),
                           16'($urandom_range(2, 60)), 16'($urandom_range(p == 4 ? 20 : 6)));
            // one phase runs flat out on both sides
            send_gaps_on   = (p != 1);
            recv_stalls_on = (p != 1);
            if (p == 2)
            begin
                gen_presses(55);
                // sender holds off until every result is back
                wait_idle();
                gen_presses(55);
            end
            else
            begin
                gen_presses(p == 3 ? 40 : 110);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && step_result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
